// ===== design/shp_pkg.sv =====
// Shared types and constants for the Serial Wire Debug host physical layer.
package shp_pkg;

    // Command codes
    localparam logic [2:0] OP_ENABLE     = 3'd0;
    localparam logic [2:0] OP_LINE_RESET = 3'd1;
    localparam logic [2:0] OP_SELECT     = 3'd2;
    localparam logic [2:0] OP_IDLE       = 3'd3;
    localparam logic [2:0] OP_REQUEST    = 3'd4;
    localparam logic [2:0] OP_TURNAROUND = 3'd5;
    localparam logic [2:0] OP_READ       = 3'd6;
    localparam logic [2:0] OP_WRITE      = 3'd7;

    // Protocol constants
    localparam int          WORD_BITS   = 32;
    localparam int          TARGET_BITS = WORD_BITS + 1;
    localparam int          REQ_BITS    = 8;
    localparam int          ACK_BITS    = 3;
    localparam int          SELECT_BITS = 16;
    localparam logic [15:0] SELECT_SEQ  = 16'hE79E;

    // Packed widths of the stream payloads
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;

    // Controls from the sequencer to the shift registers
    typedef struct packed {
        logic load;
        logic tx_shift;
        logic rx_shift;
    } dp_ctrl_t;

endpackage

// ===== design/shp_tx.sv =====
// Transmit shift register with a running even-parity accumulator.
module shp_tx (
    input  logic                              clk,
    input  shp_pkg::dp_ctrl_t                 ctrl,
    input  logic [shp_pkg::WORD_BITS-1:0]     load_value,
    output logic                              tx_bit,
    output logic                              tx_parity
);
    import shp_pkg::*;

    logic [WORD_BITS-1:0] shift_reg;
    logic [WORD_BITS-1:0] shift_next;
    logic                 par_reg;
    logic                 par_next;

    // Load at command start, then move one bit out per SWCLK cycle.
    always_comb
    begin
        shift_next = shift_reg;
        par_next   = par_reg;
        if (ctrl.load)
        begin
            shift_next = load_value;
            par_next   = 1'b0;
        end
        else if (ctrl.tx_shift)
        begin
            shift_next = {1'b0, shift_reg[WORD_BITS-1:1]};
            par_next   = par_reg ^ shift_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        par_reg   <= par_next;
    end

    assign tx_bit    = shift_reg[0];
    assign tx_parity = par_reg;

endmodule

// ===== design/shp_rx.sv =====
// Receive path: target bit source, sampled word shift register and parity.
module shp_rx (
    input  logic                              clk,
    input  shp_pkg::dp_ctrl_t                 ctrl,
    input  logic [shp_pkg::TARGET_BITS-1:0]   target_bits,
    output logic                              in_bit,
    output logic [shp_pkg::WORD_BITS-1:0]     data_word,
    output logic                              rx_parity
);
    import shp_pkg::*;

    logic [TARGET_BITS-1:0] src_reg;
    logic [TARGET_BITS-1:0] src_next;
    logic [WORD_BITS-1:0]   data_reg;
    logic [WORD_BITS-1:0]   data_next;
    logic                   par_reg;
    logic                   par_next;

    // The target's bits arrive LSB first; each sampled bit enters the word at the top.
    always_comb
    begin
        src_next  = src_reg;
        data_next = data_reg;
        par_next  = par_reg;
        if (ctrl.load)
        begin
            src_next = target_bits;
            par_next = 1'b0;
        end
        else if (ctrl.rx_shift)
        begin
            src_next  = {1'b0, src_reg[TARGET_BITS-1:1]};
            data_next = {src_reg[0], data_reg[WORD_BITS-1:1]};
            par_next  = par_reg ^ src_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg  <= src_next;
        data_reg <= data_next;
        par_reg  <= par_next;
    end

    assign in_bit    = src_reg[0];
    assign data_word = data_reg;
    assign rx_parity = par_reg;

endmodule

// ===== design/swd_host_phy.sv =====
// Top level of the Serial Wire Debug host physical layer: sequencer, pin state and output stage.
//
// Usage: one command enters on the s_ side as a transaction; the block then
// gives one result transaction per SWCLK cycle on the m_ side, the final one
// marked by m_tlast and, for a request or a read, carrying the acknowledge or read data.
// The results of a command number 1 for enable or turnaround, LINE_RESET_CYCLES
// for line reset, 16 for select, IDLE_BITS for idle, 12 for request and 33 for
// read or write. An accepted command is first registered in the sequencer,
// and each step of the sequencer then registers one result in the output
// stage. The cycle counter of the sequencer counts the steps; in the commands
// that shift, one bit moves through the transmit or the receive shift register
// per cycle while the receiver does not stall.
// s_tready is high only while no command is in progress.
// Reset clears the pin state (SWDIO low and floating, SWCLK floating), the
// busy flag of the sequencer and the valid flag of the output stage.
// When the receiver holds m_tready low, the registered result stays and the
// sequencer waits; no result is lost or repeated.
module swd_host_phy #(
    parameter int LINE_RESET_CYCLES = 50,
    parameter int IDLE_BITS         = 9
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation[2:0], direction_flag[3], request_byte[11:4], write_value[43:12],
    // target_bits[76:44], zero padding[79:77]
    input  logic [shp_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // clock_pulse[0], swdio_level[1], swdio_drive[2], swclk_drive[3],
    // ack_code[6:4], read_data[38:7], parity_ok[39]
    output logic [shp_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);
    import shp_pkg::*;

    localparam int MAX_A   = (LINE_RESET_CYCLES > IDLE_BITS) ? LINE_RESET_CYCLES : IDLE_BITS;
    localparam int MAX_LEN = (MAX_A > TARGET_BITS) ? MAX_A : TARGET_BITS;
    localparam int CNT_W   = $clog2(MAX_LEN);

    localparam logic [CNT_W-1:0] LR_LAST   = CNT_W'(LINE_RESET_CYCLES - 1);
    localparam logic [CNT_W-1:0] IDLE_LAST = CNT_W'(IDLE_BITS - 1);
    localparam logic [CNT_W-1:0] SEL_LAST  = CNT_W'(SELECT_BITS - 1);
    localparam logic [CNT_W-1:0] REQ_TURN  = CNT_W'(REQ_BITS);
    localparam logic [CNT_W-1:0] REQ_LAST  = CNT_W'(REQ_BITS + ACK_BITS);
    localparam logic [CNT_W-1:0] WORD_LAST = CNT_W'(WORD_BITS);

    // Input fields
    logic [2:0]             in_op;
    logic                   in_flag;
    logic [REQ_BITS-1:0]    in_req;
    logic [WORD_BITS-1:0]   in_wval;
    logic [TARGET_BITS-1:0] in_tbits;

    assign in_op    = s_tdata[2:0];
    assign in_flag  = s_tdata[3];
    assign in_req   = s_tdata[11:4];
    assign in_wval  = s_tdata[43:12];
    assign in_tbits = s_tdata[76:44];

    // Sequencer and pin state
    logic             busy_reg,  busy_next;
    logic [2:0]       op_reg,    op_next;
    logic             flag_reg,  flag_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             lvl_reg,   lvl_next;
    logic             dd_reg,    dd_next;
    logic             cd_reg,    cd_next;

    // Output stage
    logic                 ov_reg,    ov_next;
    logic                 oclk_reg,  oclk_next;
    logic                 olvl_reg,  olvl_next;
    logic                 odrv_reg,  odrv_next;
    logic                 ocd_reg,   ocd_next;
    logic [ACK_BITS-1:0]  oack_reg,  oack_next;
    logic [WORD_BITS-1:0] odata_reg, odata_next;
    logic                 ook_reg,   ook_next;
    logic                 olast_reg, olast_next;

    logic                 accept;
    logic                 step;
    dp_ctrl_t             ctrl;
    logic [WORD_BITS-1:0] tx_load;
    logic                 tx_bit;
    logic                 tx_parity;
    logic                 in_bit;
    logic [WORD_BITS-1:0] data_word;
    logic                 rx_parity;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && !busy_reg;
    assign step     = busy_reg && (!ov_reg || m_tready);

    // Word that the transmit register starts from, chosen by the command.
    always_comb
    begin
        case (in_op)
            OP_SELECT:  tx_load = WORD_BITS'(SELECT_SEQ);
            OP_REQUEST: tx_load = WORD_BITS'(in_req);
            OP_WRITE:   tx_load = in_wval;
            default:    tx_load = '0;
        endcase
    end

    shp_tx u_tx (
        .clk        (clk),
        .ctrl       (ctrl),
        .load_value (tx_load),
        .tx_bit     (tx_bit),
        .tx_parity  (tx_parity)
    );

    shp_rx u_rx (
        .clk         (clk),
        .ctrl        (ctrl),
        .target_bits (in_tbits),
        .in_bit      (in_bit),
        .data_word   (data_word),
        .rx_parity   (rx_parity)
    );

    // One SWCLK cycle of the current command per step.
    always_comb
    begin
        busy_next  = busy_reg;
        op_next    = op_reg;
        flag_next  = flag_reg;
        cnt_next   = cnt_reg;
        lvl_next   = lvl_reg;
        dd_next    = dd_reg;
        cd_next    = cd_reg;
        ov_next    = ov_reg && !m_tready;
        oclk_next  = oclk_reg;
        olvl_next  = olvl_reg;
        odrv_next  = odrv_reg;
        ocd_next   = ocd_reg;
        oack_next  = oack_reg;
        odata_next = odata_reg;
        ook_next   = ook_reg;
        olast_next = olast_reg;
        ctrl       = '0;

        if (accept)
        begin
            busy_next = 1'b1;
            op_next   = in_op;
            flag_next = in_flag;
            cnt_next  = '0;
            ctrl.load = 1'b1;
        end
        else if (step)
        begin
            ov_next    = 1'b1;
            oclk_next  = 1'b1;
            oack_next  = '0;
            odata_next = '0;
            ook_next   = 1'b0;
            olast_next = 1'b0;
            odrv_next  = dd_reg;
            cnt_next   = cnt_reg + 1'b1;
            case (op_reg)
                OP_ENABLE:
                begin
                    oclk_next  = 1'b0;
                    olast_next = 1'b1;
                    dd_next    = flag_reg;
                    cd_next    = flag_reg;
                    if (flag_reg)
                    begin
                        lvl_next = 1'b1;
                    end
                    odrv_next = flag_reg;
                end
                OP_LINE_RESET:
                begin
                    lvl_next   = 1'b1;
                    olast_next = (cnt_reg == LR_LAST);
                end
                OP_SELECT:
                begin
                    lvl_next      = tx_bit;
                    ctrl.tx_shift = 1'b1;
                    olast_next    = (cnt_reg == SEL_LAST);
                end
                OP_IDLE:
                begin
                    lvl_next   = 1'b0;
                    olast_next = (cnt_reg == IDLE_LAST);
                end
                OP_REQUEST:
                begin
                    if (cnt_reg < REQ_TURN)
                    begin
                        lvl_next      = tx_bit;
                        ctrl.tx_shift = 1'b1;
                    end
                    else if (cnt_reg == REQ_TURN)
                    begin
                        lvl_next  = 1'b1;
                        dd_next   = 1'b0;
                        odrv_next = 1'b0;
                    end
                    else
                    begin
                        ctrl.rx_shift = 1'b1;
                        if (cnt_reg == REQ_LAST)
                        begin
                            olast_next = 1'b1;
                            oack_next  = {in_bit, data_word[WORD_BITS-1:WORD_BITS-2]};
                        end
                    end
                end
                OP_TURNAROUND:
                begin
                    lvl_next   = 1'b1;
                    odrv_next  = 1'b0;
                    dd_next    = flag_reg;
                    olast_next = 1'b1;
                end
                OP_READ:
                begin
                    ctrl.rx_shift = 1'b1;
                    if (cnt_reg == WORD_LAST)
                    begin
                        olast_next = 1'b1;
                        odata_next = data_word;
                        ook_next   = (in_bit == rx_parity);
                    end
                end
                default:
                begin
                    if (cnt_reg == WORD_LAST)
                    begin
                        lvl_next   = tx_parity;
                        olast_next = 1'b1;
                    end
                    else
                    begin
                        lvl_next      = tx_bit;
                        ctrl.tx_shift = 1'b1;
                    end
                end
            endcase
            olvl_next = lvl_next;
            ocd_next  = cd_next;
            if (olast_next)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            lvl_reg  <= 1'b0;
            dd_reg   <= 1'b0;
            cd_reg   <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            lvl_reg  <= lvl_next;
            dd_reg   <= dd_next;
            cd_reg   <= cd_next;
            ov_reg   <= ov_next;
        end
    end

    // Command and result payload
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        flag_reg  <= flag_next;
        cnt_reg   <= cnt_next;
        oclk_reg  <= oclk_next;
        olvl_reg  <= olvl_next;
        odrv_reg  <= odrv_next;
        ocd_reg   <= ocd_next;
        oack_reg  <= oack_next;
        odata_reg <= odata_next;
        ook_reg   <= ook_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {ook_reg, odata_reg, oack_reg, ocd_reg, odrv_reg, olvl_reg, oclk_reg};

`ifndef ASSERT_OFF
    // Sampled acknowledge and read data appear only on the final result of a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[39:4] == '0))
        else $error("sampled fields set on a result that is not final");

    // Only an enable gives a result without a clock pulse, and it is a single result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> m_tlast)
        else $error("pin update without clock is not a final result");

    // A command once accepted holds off the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again straight after a command");

    // A registered result holds while the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");
`endif

endmodule

// ===== tb/swd_host_phy_tb.sv =====
// Self-checking testbench for the Serial Wire Debug host physical layer.
`timescale 1ns / 1ps

module swd_host_phy_tb;

    import shp_pkg::*;

    localparam int LINE_RESET_CYCLES = 50;
    localparam int IDLE_BITS         = 9;
    localparam int RANDOM_CMDS       = 80;
    localparam int SETTLE_CYCLES     = 20;
    localparam int MAX_REPORTS       = 10;

    // One command as it is packed into s_tdata, last field in the lowest bits.
    typedef struct packed {
        logic [32:0] tbits;
        logic [31:0] wval;
        logic [7:0]  req;
        logic        flag;
        logic [2:0]  op;
    } swd_cmd_t;

    // One SWCLK cycle as the block should report it.
    typedef struct {
        bit        pulse;
        bit        level;
        bit        sdrive;
        bit        cdrive;
        bit [2:0]  ack;
        bit [31:0] data;
        bit        pok;
        bit        last;
    } pin_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    swd_cmd_t  pending_cmds[$];
    pin_beat_t expected_beats[$];

    // Predicted pin state.
    bit pin_level;
    bit pin_driven;
    bit clk_driven;

    bit took = 1'b0;
    int gap_left = 0;
    int burst_left = 1;
    int rx_cycle = 0;
    int total_cmds = 0;
    int accepted = 0;
    int beats_checked = 0;
    int mismatches = 0;
    int op_seen[8];

    swd_host_phy #(
        .LINE_RESET_CYCLES(LINE_RESET_CYCLES),
        .IDLE_BITS        (IDLE_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reset is held low from the start and released on a falling edge.
    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            report($sformatf("beat %0d %s expected %0h actual %0h",
                             beats_checked, name, want, got));
        end
    endtask

    // Appends one expected cycle, taking the SWDIO level from the predicted state.
    task automatic push_beat(input bit pulse, input bit drive, input bit [2:0] ack,
                             input bit [31:0] data, input bit pok, input bit last);
        pin_beat_t b;
        b.pulse  = pulse;
        b.level  = pin_level;
        b.sdrive = drive;
        b.cdrive = clk_driven;
        b.ack    = ack;
        b.data   = data;
        b.pok    = pok;
        b.last   = last;
        expected_beats.push_back(b);
    endtask

    // Host-driven bits, sent LSB first.
    task automatic shift_out(input bit [31:0] value, input int count, input bit fin);
        int i;
        for (i = 0; i < count; i++)
        begin
            pin_level = value[i];
            push_beat(1'b1, pin_driven, 3'd0, 32'd0, 1'b0, fin && (i == count - 1));
        end
    endtask

    // Works out every SWCLK cycle that one command should produce.
    task automatic model_command(input swd_cmd_t c);
        bit [31:0] word;
        bit        ok;
        int        i;
        word = c.tbits[31:0];
        ok   = (c.tbits[32] == ^word);
        case (c.op)
            OP_ENABLE:
            begin
                if (c.flag)
                begin
                    pin_driven = 1'b1;
                    clk_driven = 1'b1;
                    pin_level  = 1'b1;
                end
                else
                begin
                    pin_driven = 1'b0;
                    clk_driven = 1'b0;
                end
                push_beat(1'b0, pin_driven, 3'd0, 32'd0, 1'b0, 1'b1);
            end
            OP_LINE_RESET:
            begin
                for (i = 0; i < LINE_RESET_CYCLES; i++)
                begin
                    pin_level = 1'b1;
                    push_beat(1'b1, pin_driven, 3'd0, 32'd0, 1'b0,
                              i == LINE_RESET_CYCLES - 1);
                end
            end
            OP_SELECT:
            begin
                shift_out({16'h0000, SELECT_SEQ}, SELECT_BITS, 1'b1);
            end
            OP_IDLE:
            begin
                shift_out(32'd0, IDLE_BITS, 1'b1);
            end
            OP_REQUEST:
            begin
                shift_out({24'd0, c.req}, REQ_BITS, 1'b0);
                pin_level  = 1'b1;
                pin_driven = 1'b0;
                push_beat(1'b1, 1'b0, 3'd0, 32'd0, 1'b0, 1'b0);
                for (i = 0; i < ACK_BITS; i++)
                begin
                    push_beat(1'b1, pin_driven,
                              (i == ACK_BITS - 1) ? c.tbits[2:0] : 3'd0,
                              32'd0, 1'b0, i == ACK_BITS - 1);
                end
            end
            OP_TURNAROUND:
            begin
                pin_level  = 1'b1;
                pin_driven = 1'b0;
                push_beat(1'b1, 1'b0, 3'd0, 32'd0, 1'b0, 1'b1);
                pin_driven = c.flag;
            end
            OP_READ:
            begin
                for (i = 0; i <= WORD_BITS; i++)
                begin
                    push_beat(1'b1, pin_driven, 3'd0,
                              (i == WORD_BITS) ? word : 32'd0,
                              (i == WORD_BITS) ? ok : 1'b0, i == WORD_BITS);
                end
            end
            default:
            begin
                shift_out(c.wval, WORD_BITS, 1'b0);
                shift_out({31'd0, ^c.wval}, 1, 1'b1);
            end
        endcase
    endtask

    task automatic queue_cmd(input logic [2:0] op, input logic flag, input logic [7:0] req,
                             input logic [31:0] wval, input logic [32:0] tbits);
        swd_cmd_t c;
        c.op    = op;
        c.flag  = flag;
        c.req   = req;
        c.wval  = wval;
        c.tbits = tbits;
        pending_cmds.push_back(c);
    endtask

    // Data words lean towards the all-zero and all-one extremes now and then.
    function automatic logic [31:0] rand_word();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            return 32'h0000_0000;
        end
        else if (pick == 1)
        begin
            return 32'hFFFF_FFFF;
        end
        return $urandom;
    endfunction

    task automatic queue_switch_to_swd();
        queue_cmd(OP_LINE_RESET, 1'b0, 8'h00, 32'd0, 33'd0);
        queue_cmd(OP_SELECT, 1'b0, 8'h00, 32'd0, 33'd0);
        queue_cmd(OP_LINE_RESET, 1'b0, 8'h00, 32'd0, 33'd0);
        queue_cmd(OP_IDLE, 1'b0, 8'h00, 32'd0, 33'd0);
    endtask

    // Stimulus: directed commands first, then random SWD transfers and noise.
    initial
    begin : stimulus
        int        pick;
        bit        rnw;
        bit [7:0]  hdr;
        bit [2:0]  ack;
        bit [31:0] word;
        bit [32:0] tb;

        // Commands issued while the port is still floating.
        queue_cmd(OP_WRITE, 1'b0, 8'h00, 32'hA5A5_5A5A, 33'd0);
        queue_cmd(OP_REQUEST, 1'b0, 8'hA5, 32'd0, 33'h0_0000_0001);
        queue_cmd(OP_READ, 1'b1, 8'h00, 32'd0, 33'h1_8000_0001);

        // Enable and the switch routine.
        queue_cmd(OP_ENABLE, 1'b1, 8'h00, 32'd0, 33'd0);
        queue_switch_to_swd();

        // Request and read with the extremes of the fields.
        queue_cmd(OP_REQUEST, 1'b0, 8'hA5, 32'd0, 33'h0_0000_0001);
        queue_cmd(OP_READ, 1'b0, 8'h00, 32'd0, 33'h1_FFFF_FFFF);
        queue_cmd(OP_TURNAROUND, 1'b1, 8'h00, 32'd0, 33'd0);
        queue_cmd(OP_REQUEST, 1'b1, 8'hFF, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
        queue_cmd(OP_TURNAROUND, 1'b1, 8'hFF, 32'd0, 33'd0);
        queue_cmd(OP_WRITE, 1'b0, 8'h00, 32'h0000_0000, 33'd0);
        queue_cmd(OP_WRITE, 1'b1, 8'hFF, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
        queue_cmd(OP_REQUEST, 1'b0, 8'h00, 32'd0, 33'd0);
        queue_cmd(OP_READ, 1'b0, 8'h00, 32'd0, 33'd0);

        // Turnaround that leaves SWDIO floating, then an output phase on it.
        queue_cmd(OP_TURNAROUND, 1'b0, 8'h00, 32'd0, 33'd0);
        queue_cmd(OP_WRITE, 1'b0, 8'h00, 32'h1234_5678, 33'd0);
        queue_cmd(OP_IDLE, 1'b1, 8'hFF, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF);

        // Disable, work on the floating port, then enable again.
        queue_cmd(OP_ENABLE, 1'b0, 8'hFF, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
        queue_cmd(OP_TURNAROUND, 1'b1, 8'h00, 32'd0, 33'd0);
        queue_cmd(OP_SELECT, 1'b1, 8'h00, 32'd0, 33'd0);
        queue_cmd(OP_ENABLE, 1'b1, 8'h00, 32'd0, 33'd0);
        queue_cmd(OP_READ, 1'b0, 8'h00, 32'd0, 33'h1_0000_0001);

        total_cmds = pending_cmds.size();

        // Random part, mostly well-formed transfers.
        while (pending_cmds.size() < total_cmds + RANDOM_CMDS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 12)
            begin
                rnw    = 1'($urandom_range(0, 1));
                hdr[0] = 1'b1;
                hdr[1] = 1'($urandom_range(0, 1));
                hdr[2] = rnw;
                hdr[4:3] = 2'($urandom_range(0, 3));
                hdr[5] = ^hdr[4:1];
                hdr[6] = 1'b0;
                hdr[7] = 1'b1;
                ack = ($urandom_range(0, 3) != 0) ? 3'b001 : 3'($urandom_range(0, 7));
                tb  = {1'($urandom_range(0, 1)), 32'($urandom)};
                tb[2:0] = ack;
                queue_cmd(OP_REQUEST, 1'($urandom_range(0, 1)), hdr, $urandom, tb);
                if (rnw)
                begin
                    word = rand_word();
                    tb = {(^word) ^ ($urandom_range(0, 3) == 0), word};
                    queue_cmd(OP_READ, 1'($urandom_range(0, 1)), 8'($urandom),
                              $urandom, tb);
                    queue_cmd(OP_TURNAROUND, 1'b1, 8'($urandom), $urandom,
                              {1'($urandom_range(0, 1)), 32'($urandom)});
                end
                else
                begin
                    queue_cmd(OP_TURNAROUND, 1'b1, 8'($urandom), $urandom,
                              {1'($urandom_range(0, 1)), 32'($urandom)});
                    queue_cmd(OP_WRITE, 1'($urandom_range(0, 1)), 8'($urandom),
                              rand_word(), {1'($urandom_range(0, 1)), 32'($urandom)});
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    queue_cmd(OP_IDLE, 1'($urandom_range(0, 1)), 8'($urandom),
                              $urandom, {1'($urandom_range(0, 1)), 32'($urandom)});
                end
            end
            else if (pick == 12)
            begin
                queue_switch_to_swd();
            end
            else if (pick == 13)
            begin
                queue_cmd(OP_ENABLE, ($urandom_range(0, 2) != 0), 8'($urandom),
                          $urandom, {1'($urandom_range(0, 1)), 32'($urandom)});
            end
            else
            begin
                // Noise: any command with any field contents.
                queue_cmd(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                          8'($urandom), $urandom,
                          {1'($urandom_range(0, 1)), 32'($urandom)});
            end
        end
        total_cmds = pending_cmds.size();
    end

    // Sender: commands go out in bursts separated by random gaps.
    always @(negedge clk)
    begin : driver
        if (rst_n)
        begin
            if (!s_tvalid || took)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    s_tdata  <= {3'b000, pending_cmds.pop_front()};
                    s_tvalid <= 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60)
                                                               : $urandom_range(0, 4);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end

            // Receiver: a rotating pattern of no stalls, light, heavy and periodic stalls.
            case ((rx_cycle / 400) % 4)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((rx_cycle % 7) >= 3);
            endcase
            rx_cycle = rx_cycle + 1;
        end
    end

    // Monitor: predicts each accepted command and checks each result transaction.
    always @(posedge clk)
    begin : monitor
        pin_beat_t b;
        if (rst_n)
        begin
            took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                model_command(s_tdata[76:0]);
                op_seen[s_tdata[2:0]]++;
                accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    report($sformatf("result with nothing expected, tdata %0h tlast %0b",
                                     m_tdata, m_tlast));
                end
                else
                begin
                    b = expected_beats.pop_front();
                    check_field("clock_pulse", b.pulse, m_tdata[0]);
                    check_field("swdio_level", b.level, m_tdata[1]);
                    check_field("swdio_drive", b.sdrive, m_tdata[2]);
                    check_field("swclk_drive", b.cdrive, m_tdata[3]);
                    check_field("ack_code", b.ack, m_tdata[6:4]);
                    check_field("read_data", b.data, m_tdata[38:7]);
                    check_field("parity_ok", b.pok, m_tdata[39]);
                    check_field("last", b.last, m_tlast);
                end
                beats_checked++;
            end
        end
    end

    // End of run: drain, settle, then give the verdict.
    initial
    begin : finisher
        @(posedge rst_n);
        while (total_cmds == 0 || accepted < total_cmds)
        begin
            @(posedge clk);
        end
        while (expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_beats.size() != 0)
        begin
            report($sformatf("%0d results never arrived", expected_beats.size()));
        end
        $display("Ran %0d commands: enable %0d, line reset %0d, select %0d, idle %0d,",
                 accepted, op_seen[OP_ENABLE], op_seen[OP_LINE_RESET],
                 op_seen[OP_SELECT], op_seen[OP_IDLE]);
        $display("request %0d, turnaround %0d, read %0d, write %0d; %0d results, %0d bad",
                 op_seen[OP_REQUEST], op_seen[OP_TURNAROUND], op_seen[OP_READ],
                 op_seen[OP_WRITE], beats_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("swd_host_phy_tb: PASS");
        end
        else
        begin
            $display("swd_host_phy_tb: FAIL");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin : watchdog
        #2_000_000;
        $display("swd_host_phy_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/shp_pkg.sv
design/shp_tx.sv
design/shp_rx.sv
design/swd_host_phy.sv
tb/swd_host_phy_tb.sv
